[rtl/mms_pkg.sv]
`default_nettype none
package mms_pkg;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Field widths fixed by the interface
  localparam int ItemWidth  = 32;
  localparam int CountWidth = 7;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mms_status_t;

  typedef struct packed {
    logic                        operation;
    logic signed [ItemWidth-1:0] push_value;
  } mms_in_t;

  typedef struct packed {
    logic signed [ItemWidth-1:0] popped_value;
    logic signed [ItemWidth-1:0] current_max;
    logic signed [ItemWidth-1:0] current_min;
    logic [CountWidth-1:0]       entry_count;
    mms_status_t                 status;
  } mms_out_t;

  // Shift control broadcast to every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
  } mms_shift_t;

endpackage
`default_nettype wire

[rtl/min_max_stack_core.sv]
`default_nettype none
// An accepted item shows its result in the output register in the next cycle.
// Throughput: one item per cycle while no stalled result holds the input; the stack is
// a row of cells that all shift in the cycle of the push or pop, with the top entry always in the first cell.
// Reset (rst_n low, synchronous): entry count cleared, capacity set to 64,
// output register emptied; cell contents are not cleared.
module min_max_stack_core
  import mms_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire mms_in_t               in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output mms_out_t                   out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CountWidth-1:0] cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CountWidth) ? CW : CountWidth;
  localparam int EW = 3 * VALUE_WIDTH;

  logic [CountWidth-1:0] capacity_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  mms_out_t              out_item_r, out_item_nxt;

  logic [EW-1:0] cell_q [DEPTH];
  logic [EW-1:0] new_entry;
  mms_shift_t    shift;

  logic                          accept;
  logic                          is_empty, is_full, one_left;
  logic [MW-1:0]                 cap_eff;
  logic signed [VALUE_WIDTH-1:0] v, mx, mn;
  logic signed [VALUE_WIDTH-1:0] top_val, top_max, top_min, nxt_max, nxt_min;

  // Configuration: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CountWidth'(64);
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // Handshake: stall only while a result waits and is itself stalled
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Top and next-to-top entries
  assign top_val = cell_q[0][EW-1:2*VALUE_WIDTH];
  assign top_max = cell_q[0][2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign top_min = cell_q[0][VALUE_WIDTH-1:0];
  assign nxt_max = cell_q[1][2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign nxt_min = cell_q[1][VALUE_WIDTH-1:0];

  // Status of the stack
  assign cap_eff  = (MW'(capacity_r) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(capacity_r);
  assign is_empty = (count_r == '0);
  assign is_full  = (MW'(count_r) >= cap_eff);
  assign one_left = (count_r == CW'(1));

  // New entry: value with running max and min
  assign v  = VALUE_WIDTH'($signed(in_item.push_value));
  assign mx = (!is_empty && (v < top_max)) ? top_max : v;
  assign mn = (!is_empty && (top_min < v)) ? top_min : v;
  assign new_entry = {v, mx, mn};

  // Shift control and result
  always_comb begin
    shift        = '0;
    count_nxt    = count_r;
    out_item_nxt = out_item_r;
    out_item_nxt.popped_value = '0;
    out_item_nxt.status       = ST_OK;
    if (in_item.operation == OP_PUSH) begin
      if (is_full) begin
        out_item_nxt.status      = ST_FULL;
        out_item_nxt.current_max = is_empty ? '0 : ItemWidth'(top_max);
        out_item_nxt.current_min = is_empty ? '0 : ItemWidth'(top_min);
      end else begin
        shift.push               = accept;
        count_nxt                = count_r + CW'(1);
        out_item_nxt.current_max = ItemWidth'(mx);
        out_item_nxt.current_min = ItemWidth'(mn);
      end
    end else begin
      if (is_empty) begin
        out_item_nxt.status      = ST_EMPTY;
        out_item_nxt.current_max = '0;
        out_item_nxt.current_min = '0;
      end else begin
        shift.pop                 = accept;
        count_nxt                 = count_r - CW'(1);
        out_item_nxt.popped_value = ItemWidth'(top_val);
        out_item_nxt.current_max  = one_left ? '0 : ItemWidth'(nxt_max);
        out_item_nxt.current_min  = one_left ? '0 : ItemWidth'(nxt_min);
      end
    end
    out_item_nxt.entry_count = CountWidth'(count_nxt);
  end

  // Drop the result once taken, load a new one on accept
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Row of cells, top entry in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] up_d, dn_d;
    if (i == 0) begin : g_first
      assign up_d = new_entry;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign dn_d = '0;
    end else begin : g_inner
      assign dn_d = cell_q[i+1];
    end
    mms_cell #(
      .WIDTH(EW)
    ) u_cell (
      .clk    (clk),
      .ctrl   (shift),
      .up_data(up_d),
      .dn_data(dn_d),
      .q      (cell_q[i])
    );
  end

endmodule
`default_nettype wire

[rtl/mms_cell.sv]
`default_nettype none
module mms_cell
  import mms_pkg::*;
#(
  parameter int WIDTH = 96
) (
  input  wire logic             clk,
  input  wire mms_shift_t       ctrl,
  input  wire logic [WIDTH-1:0] up_data,
  input  wire logic [WIDTH-1:0] dn_data,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] q_r;

  // Take the entry from above on push, from below on pop, else hold
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q_r <= up_data;
    end else if (ctrl.pop) begin
      q_r <= dn_data;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

[tb/sv/tb_min_max_stack_core.sv]
module tb_min_max_stack_core;
  import mms_pkg::*;

  localparam int Depth    = 64;
  localparam int IdlePct  = 14;
  localparam int HoldAt   = 900;
  localparam int HoldLen  = 300;
  localparam int NumPhase = 12;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  mms_in_t               in_item   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CountWidth-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  cfg_ready;
  mms_out_t              out_item;

  min_max_stack_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ops waiting to be offered and results waiting to arrive
  mms_in_t  op_backlog[$];
  mms_out_t report_due[$];

  // Shadow copy of the stack and its capacity register
  logic signed [ItemWidth-1:0] stk_value[Depth];
  logic signed [ItemWidth-1:0] stk_max[Depth];
  logic signed [ItemWidth-1:0] stk_min[Depth];
  int unsigned stk_count;
  int unsigned cap_limit;

  int  items_queued = 0;
  int  items_taken  = 0;
  int  cfg_writes   = 0;
  int  errors       = 0;
  int  n_push_ok    = 0;
  int  n_pop_ok     = 0;
  int  n_full       = 0;
  int  n_empty      = 0;
  int  peak_count   = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  steady       = 1'b0;
  bit  in_fire      = 1'b0;

  // Apply one op to the shadow stack and return the result it must produce
  function automatic mms_out_t apply_stack_op(mms_in_t op);
    mms_out_t    r;
    int unsigned room;
    r = '0;
    r.status = ST_OK;
    room = (cap_limit > Depth) ? Depth : cap_limit;
    if (op.operation == OP_PUSH) begin
      if (stk_count >= room) begin
        r.status = ST_FULL;
      end else begin
        stk_value[stk_count] = op.push_value;
        stk_max[stk_count]   = op.push_value;
        stk_min[stk_count]   = op.push_value;
        if (stk_count > 0) begin
          if (stk_max[stk_count-1] > op.push_value) stk_max[stk_count] = stk_max[stk_count-1];
          if (stk_min[stk_count-1] < op.push_value) stk_min[stk_count] = stk_min[stk_count-1];
        end
        stk_count++;
      end
    end else if (stk_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      stk_count--;
      r.popped_value = stk_value[stk_count];
    end
    if (stk_count > 0) begin
      r.current_max = stk_max[stk_count-1];
      r.current_min = stk_min[stk_count-1];
    end
    r.entry_count = CountWidth'(stk_count);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t: MISMATCH %s", $time, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Predict on accepted items and compare accepted results
  always @(posedge clk) begin
    mms_out_t want;
    if (!rst_n) begin
      stk_count = 0;
      cap_limit = Depth;
      in_fire   = 1'b0;
      report_due.delete();
    end else begin
      in_fire = in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        cap_limit = cfg_data;
        cfg_writes++;
      end
      if (in_fire) begin
        want = apply_stack_op(in_item);
        report_due.push_back(want);
        items_taken++;
        case (want.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default: begin
            if (in_item.operation == OP_PUSH) n_push_ok++;
            else n_pop_ok++;
          end
        endcase
        if (stk_count > peak_count) peak_count = stk_count;
      end
      if (out_valid && !out_stall) begin
        if (report_due.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = report_due.pop_front();
          check_field("popped_value", out_item.popped_value, want.popped_value);
          check_field("current_max", out_item.current_max, want.current_max);
          check_field("current_min", out_item.current_min, want.current_min);
          check_field("entry_count", 32'(out_item.entry_count), 32'(want.entry_count));
          check_field("status", 32'(out_item.status), 32'(want.status));
        end
      end
    end
  end

  // Offer backlog items, holding each one until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the stalled item
    end else if (op_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
      in_item  <= op_backlog.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result side at random, or throughout a hold-off
  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || (!steady && $urandom_range(0, 99) < IdlePct);
  end

  // Count down one long hold-off on the result side
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HoldAt) begin
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end
  end

  task automatic queue_op(logic op, logic signed [ItemWidth-1:0] value);
    mms_in_t it;
    it.operation  = op;
    it.push_value = value;
    op_backlog.push_back(it);
    items_queued++;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    wait (items_taken == items_queued && report_due.size() == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(int v);
    int seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data  <= CountWidth'(v);
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Extremes, near-equal values and plain random words
  function automatic logic signed [ItemWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int n, int push_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct) queue_op(OP_PUSH, pick_value());
      else queue_op(OP_POP, $urandom);
    end
  endtask

  initial begin
    int caps[NumPhase]     = '{64, 127, 100, 5, 1, 0, 33, 64, 2, 63, 17, -1};
    int push_pcts[NumPhase] = '{75, 60, 80, 40, 50, 50, 65, 70, 50, 85, 45, 30};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Pop on empty, extremes, equal minimum, then unwind past empty
    queue_op(OP_POP, 32'sh5a5a5a5a);
    queue_op(OP_PUSH, 32'sh7fffffff);
    queue_op(OP_PUSH, 32'sh80000000);
    queue_op(OP_PUSH, '0);
    queue_op(OP_PUSH, -32'sd1);
    queue_op(OP_PUSH, 32'sd1);
    queue_op(OP_PUSH, 32'sh80000000);
    repeat (7) queue_op(OP_POP, '0);
    drain();

    // Capacity one: second push refused
    write_capacity(1);
    queue_op(OP_PUSH, 32'sd5);
    queue_op(OP_PUSH, 32'sd6);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);
    drain();

    // Capacity zero refuses every push
    write_capacity(0);
    queue_op(OP_PUSH, 32'sd3);
    drain();

    // Capacity above depth, then cut below the count
    write_capacity(127);
    queue_op(OP_PUSH, 32'sd10);
    queue_op(OP_PUSH, -32'sd20);
    queue_op(OP_PUSH, 32'sd30);
    drain();
    write_capacity(2);
    queue_op(OP_PUSH, 32'sd40);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_PUSH, 32'sd50);
    drain();

    // Random walks, one capacity per phase; entries carry over between phases
    for (int p = 0; p < NumPhase; p++) begin
      write_capacity(caps[p] < 0 ? $urandom_range(0, 127) : caps[p]);
      steady = (p == 3);
      queue_random(135, push_pcts[p]);
      drain();
    end
    steady = 1'b0;

    $display("Ran %0d items: %0d pushes, %0d pops, %0d refused full, %0d refused empty",
             items_taken, n_push_ok, n_pop_ok, n_full, n_empty);
    $display("Peak depth %0d over %0d capacity settings", peak_count, cfg_writes);
    if (errors == 0 && report_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up if the run stops making progress
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
rtl/mms_pkg.sv
rtl/mms_cell.sv
rtl/min_max_stack_core.sv
tb/sv/tb_min_max_stack_core.sv
